@@ rtl/mfill_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package mfill_pkg;

  localparam int GRID_SIDE = 16;

  localparam logic [1:0] DIR_N = 2'd0;
  localparam logic [1:0] DIR_S = 2'd1;
  localparam logic [1:0] DIR_E = 2'd2;
  localparam logic [1:0] DIR_W = 2'd3;

  localparam logic [2:0] REQ_FORWARD = 3'd0;
  localparam logic [2:0] REQ_LEFT    = 3'd1;
  localparam logic [2:0] REQ_RIGHT   = 3'd2;
  localparam logic [2:0] REQ_SENSE   = 3'd3;
  localparam logic [2:0] REQ_FRONT   = 3'd4;
  localparam logic [2:0] REQ_CLEAR   = 3'd5;
  localparam logic [2:0] REQ_PLAN    = 3'd6;
  localparam logic [2:0] REQ_STATUS  = 3'd7;

  localparam logic [1:0] CFG_LEFT_THR  = 2'd0;
  localparam logic [1:0] CFG_RIGHT_THR = 2'd1;
  localparam logic [1:0] CFG_GOAL_COL  = 2'd2;
  localparam logic [1:0] CFG_GOAL_ROW  = 2'd3;

  localparam int          PW             = 7;
  localparam logic [12:0] SIDE_TOLERANCE = 13'd25;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FLOOD,
    ST_CHECK,
    ST_TRACK,
    ST_DONE
  } state_t;

  // Broadcast from the controller to every cell of the grid.
  typedef struct packed {
    logic          flood_init;
    logic          wave_en;
    logic          tok_start;
    logic          tok_en;
    logic          wall_we;
    logic          wall_clr;
    logic [3:0]    wall_set;
    logic [PW-1:0] sel_col;
    logic [PW-1:0] sel_row;
    logic [PW-1:0] goal_col;
    logic [PW-1:0] goal_row;
  } cmd_t;

  function automatic logic [1:0] left_of(input logic [1:0] d);
    case (d)
      DIR_N:   left_of = DIR_W;
      DIR_S:   left_of = DIR_E;
      DIR_E:   left_of = DIR_N;
      default: left_of = DIR_S;
    endcase
  endfunction

  function automatic logic [1:0] right_of(input logic [1:0] d);
    case (d)
      DIR_N:   right_of = DIR_E;
      DIR_S:   right_of = DIR_W;
      DIR_E:   right_of = DIR_S;
      default: right_of = DIR_N;
    endcase
  endfunction

  function automatic logic [1:0] back_of(input logic [1:0] d);
    back_of = d ^ 2'd1;
  endfunction

endpackage
`default_nettype wire

@@ rtl/mfill_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface mfill_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [11:0] left_reading;
  logic [11:0] right_reading;
  modport source (output valid, req_type, left_reading, right_reading, input ready);
  modport sink (input valid, req_type, left_reading, right_reading, output ready);
endinterface

interface mfill_rsp_if;
  logic              valid;
  logic              ready;
  logic [3:0]        pos_col;
  logic [3:0]        pos_row;
  logic [1:0]        facing;
  logic              wall_ahead;
  logic              wall_left_side;
  logic              wall_right_side;
  logic              wall_behind;
  logic [3:0]        next_col;
  logic [3:0]        next_row;
  logic              next_valid;
  logic signed [8:0] goal_distance;
  modport source (output valid, pos_col, pos_row, facing, wall_ahead, wall_left_side,
                  wall_right_side, wall_behind, next_col, next_row, next_valid,
                  goal_distance, input ready);
  modport sink (input valid, pos_col, pos_row, facing, wall_ahead, wall_left_side,
                wall_right_side, wall_behind, next_col, next_row, next_valid,
                goal_distance, output ready);
endinterface

interface mfill_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [11:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/mfill_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mfill_cell #(
  parameter int         COL       = 0,
  parameter int         ROW       = 0,
  parameter int         DW        = 8,
  parameter logic [3:0] HAS_NBR   = 4'b1111,
  parameter logic [3:0] RST_WALLS = 4'b0000
) (
  input  wire                   clk,
  input  wire                   rst,
  input  mfill_pkg::cmd_t       cmd,
  input  wire  [DW-1:0]         wave,
  input  wire  [3:0][3:0]       nbr_walls,
  input  wire  [3:0]            nbr_reached,
  input  wire  [3:0][DW-1:0]    nbr_dist,
  input  wire  [3:0]            nbr_token,
  input  wire  [3:0][3:0]       nbr_choice,
  output logic [3:0]            walls,
  output logic                  reached,
  output logic [DW-1:0]         dist_val,
  output logic                  token,
  output logic [3:0]            choice
);

  logic          sel_hit;
  logic          goal_hit;
  logic [3:0]    open;
  logic [3:0]    cand;
  logic [DW-1:0] dist_dec;
  logic          tok_in;

  assign sel_hit  = (cmd.sel_col == mfill_pkg::PW'(COL)) && (cmd.sel_row == mfill_pkg::PW'(ROW));
  assign goal_hit = (cmd.goal_col == mfill_pkg::PW'(COL)) &&
                    (cmd.goal_row == mfill_pkg::PW'(ROW));
  assign dist_dec = dist_val - DW'(1);

  always_comb begin
    for (int d = 0; d < 4; d++) begin
      open[d] = HAS_NBR[d] && !walls[d] && !nbr_walls[d][d ^ 1];
      cand[d] = open[d] && nbr_reached[d] && (nbr_dist[d] == dist_dec);
    end
    // Backtrack preference: west, east, north, south.
    choice = 4'b0000;
    if (cand[mfill_pkg::DIR_W]) begin
      choice[mfill_pkg::DIR_W] = 1'b1;
    end else if (cand[mfill_pkg::DIR_E]) begin
      choice[mfill_pkg::DIR_E] = 1'b1;
    end else if (cand[mfill_pkg::DIR_N]) begin
      choice[mfill_pkg::DIR_N] = 1'b1;
    end else if (cand[mfill_pkg::DIR_S]) begin
      choice[mfill_pkg::DIR_S] = 1'b1;
    end
    // The token enters when the neighbor holding it picks the step toward this cell.
    tok_in = 1'b0;
    for (int d = 0; d < 4; d++) begin
      tok_in = tok_in | (open[d] && nbr_token[d] && nbr_choice[d][d ^ 1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walls   <= RST_WALLS;
      reached <= 1'b0;
      token   <= 1'b0;
    end else begin
      if (cmd.wall_we && sel_hit) begin
        if (cmd.wall_clr) begin
          walls <= 4'b0000;
        end else begin
          walls <= walls | cmd.wall_set;
        end
      end
      if (cmd.flood_init) begin
        reached <= sel_hit;
      end else if (cmd.wave_en && !reached && |(open & nbr_reached)) begin
        reached <= 1'b1;
      end
      if (cmd.tok_start) begin
        token <= goal_hit;
      end else if (cmd.tok_en) begin
        token <= tok_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.flood_init) begin
      dist_val <= '0;
    end else if (cmd.wave_en && !reached) begin
      dist_val <= wave;
    end
  end

endmodule
`default_nettype wire

@@ rtl/maze_mapper_flood_fill_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Every request but plan passes the execute and done states; the result is registered
// on leaving done. Plan adds flood, check and track states, track being skipped
// when the goal is unreached or is the robot's own cell: the cell grid
// advances the flood front one step per cycle, then walks a token back.
// Throughput: one item at a time; the next item is taken once the result is registered.
// Reset (rst, synchronous): start cell walls set, no cell reached, position at the
// southwest corner facing south, plan result invalid, registers at their reset values.
module maze_mapper_flood_fill_unit (
  input wire         clk,
  input wire         rst,
  mfill_req_if.sink  req,
  mfill_rsp_if.source rsp,
  mfill_cfg_if.sink  cfg
);

  localparam int GRID_SIDE = mfill_pkg::GRID_SIDE;
  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int CW    = $clog2(GRID_SIDE);
  localparam int DW    = $clog2(CELLS);
  localparam int PW    = mfill_pkg::PW;

  logic [11:0] left_thr, right_thr;
  logic [3:0]  goal_col, goal_row;

  mfill_pkg::state_t state, state_next;
  logic [2:0]   rq_type;
  logic [11:0]  rq_left, rq_right;
  logic [CW-1:0] cur_col, cur_row, cur_col_next, cur_row_next;
  logic [1:0]   heading, heading_next;
  logic [DW-1:0] wave, wave_next;
  logic [DW-1:0] cnt, cnt_next;
  logic [3:0]   plan_col, plan_row, plan_col_next, plan_row_next;
  logic         plan_valid, plan_valid_next;
  logic         out_load;
  mfill_pkg::cmd_t cmd;

  logic [CELLS-1:0][3:0]    c_walls;
  logic [CELLS-1:0]         c_reached;
  logic [CELLS-1:0][DW-1:0] c_dist;
  logic [CELLS-1:0]         c_token;
  logic [CELLS-1:0][3:0]    c_choice;

  logic [3:0]    cur_walls;
  logic          goal_reached;
  logic [DW-1:0] goal_dist;
  logic [CW-1:0] tok_col, tok_row;
  logic          goal_in;
  logic [11:0]   goal_dist_x;
  logic signed [8:0] gd_out;

  assign cfg.ready = 1'b1;
  assign req.ready = (state == mfill_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      left_thr  <= 12'd2048;
      right_thr <= 12'd2048;
      goal_col  <= 4'd7;
      goal_row  <= 4'd7;
    end else if (cfg.valid) begin
      case (cfg.index)
        mfill_pkg::CFG_LEFT_THR:  left_thr  <= cfg.data;
        mfill_pkg::CFG_RIGHT_THR: right_thr <= cfg.data;
        mfill_pkg::CFG_GOAL_COL:  goal_col  <= cfg.data[3:0];
        mfill_pkg::CFG_GOAL_ROW:  goal_row  <= cfg.data[3:0];
        default: ;
      endcase
    end
  end

  // Readback from the grid: each cell contributes only where it matches.
  always_comb begin
    cur_walls    = '0;
    goal_reached = 1'b0;
    goal_dist    = '0;
    tok_col      = '0;
    tok_row      = '0;
    for (int i = 0; i < CELLS; i++) begin
      if (PW'(i % GRID_SIDE) == PW'(cur_col) && PW'(i / GRID_SIDE) == PW'(cur_row)) begin
        cur_walls = cur_walls | c_walls[i];
      end
      if (PW'(i % GRID_SIDE) == PW'(goal_col) && PW'(i / GRID_SIDE) == PW'(goal_row)) begin
        goal_reached = goal_reached | c_reached[i];
        goal_dist    = goal_dist | c_dist[i];
      end
      if (c_token[i]) begin
        tok_col = tok_col | CW'(i % GRID_SIDE);
        tok_row = tok_row | CW'(i / GRID_SIDE);
      end
    end
  end

  assign goal_in     = (PW'(goal_col) < PW'(GRID_SIDE)) && (PW'(goal_row) < PW'(GRID_SIDE));
  assign goal_dist_x = 12'(goal_dist);

  always_comb begin
    if (!goal_in || !goal_reached) begin
      gd_out = -9'sd1;
    end else if (goal_dist_x > 12'd255) begin
      gd_out = 9'sd255;
    end else begin
      gd_out = $signed({1'b0, goal_dist_x[7:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mfill_pkg::ST_IDLE;
      cur_col    <= '0;
      cur_row    <= CW'(GRID_SIDE - 1);
      heading    <= mfill_pkg::DIR_S;
      plan_valid <= 1'b0;
      plan_col   <= '0;
      plan_row   <= '0;
    end else begin
      state      <= state_next;
      cur_col    <= cur_col_next;
      cur_row    <= cur_row_next;
      heading    <= heading_next;
      plan_valid <= plan_valid_next;
      plan_col   <= plan_col_next;
      plan_row   <= plan_row_next;
    end
  end

  always_ff @(posedge clk) begin
    wave <= wave_next;
    cnt  <= cnt_next;
    if (req.valid && req.ready) begin
      rq_type  <= req.req_type;
      rq_left  <= req.left_reading;
      rq_right <= req.right_reading;
    end
  end

  always_comb begin
    state_next      = state;
    cur_col_next    = cur_col;
    cur_row_next    = cur_row;
    heading_next    = heading;
    plan_valid_next = plan_valid;
    plan_col_next   = plan_col;
    plan_row_next   = plan_row;
    wave_next       = wave;
    cnt_next        = cnt;
    out_load        = 1'b0;
    cmd             = '0;
    cmd.sel_col     = PW'(cur_col);
    cmd.sel_row     = PW'(cur_row);
    cmd.goal_col    = PW'(goal_col);
    cmd.goal_row    = PW'(goal_row);
    case (state)
      mfill_pkg::ST_IDLE: begin
        if (req.valid) begin
          state_next = mfill_pkg::ST_EXEC;
        end
      end
      mfill_pkg::ST_EXEC: begin
        state_next = mfill_pkg::ST_DONE;
        case (rq_type)
          mfill_pkg::REQ_FORWARD: begin
            case (heading)
              mfill_pkg::DIR_N: if (cur_row != '0) cur_row_next = cur_row - CW'(1);
              mfill_pkg::DIR_S: if (cur_row != CW'(GRID_SIDE - 1)) cur_row_next = cur_row + CW'(1);
              mfill_pkg::DIR_E: if (cur_col != CW'(GRID_SIDE - 1)) cur_col_next = cur_col + CW'(1);
              default:          if (cur_col != '0) cur_col_next = cur_col - CW'(1);
            endcase
          end
          mfill_pkg::REQ_LEFT:  heading_next = mfill_pkg::left_of(heading);
          mfill_pkg::REQ_RIGHT: heading_next = mfill_pkg::right_of(heading);
          mfill_pkg::REQ_SENSE: begin
            cmd.wall_we = 1'b1;
            // reading > threshold - 25, kept unsigned as reading + 25 > threshold
            if ({1'b0, rq_left} + mfill_pkg::SIDE_TOLERANCE > {1'b0, left_thr}) begin
              cmd.wall_set[mfill_pkg::left_of(heading)] = 1'b1;
            end
            if ({1'b0, rq_right} + mfill_pkg::SIDE_TOLERANCE > {1'b0, right_thr}) begin
              cmd.wall_set[mfill_pkg::right_of(heading)] = 1'b1;
            end
          end
          mfill_pkg::REQ_FRONT: begin
            cmd.wall_we           = 1'b1;
            cmd.wall_set[heading] = 1'b1;
          end
          mfill_pkg::REQ_CLEAR: begin
            cmd.wall_we  = 1'b1;
            cmd.wall_clr = 1'b1;
          end
          mfill_pkg::REQ_PLAN: begin
            cmd.flood_init = 1'b1;
            wave_next      = DW'(1);
            state_next     = mfill_pkg::ST_FLOOD;
          end
          default: ;
        endcase
      end
      mfill_pkg::ST_FLOOD: begin
        cmd.wave_en = 1'b1;
        wave_next   = wave + DW'(1);
        if (wave == DW'(CELLS - 1)) begin
          state_next = mfill_pkg::ST_CHECK;
        end
      end
      mfill_pkg::ST_CHECK: begin
        if (goal_in && goal_reached && goal_dist != '0) begin
          cmd.tok_start = 1'b1;
          cnt_next      = goal_dist - DW'(1);
          state_next    = mfill_pkg::ST_TRACK;
        end else begin
          plan_valid_next = 1'b0;
          plan_col_next   = '0;
          plan_row_next   = '0;
          state_next      = mfill_pkg::ST_DONE;
        end
      end
      mfill_pkg::ST_TRACK: begin
        if (cnt == '0) begin
          plan_valid_next = 1'b1;
          plan_col_next   = 4'(tok_col);
          plan_row_next   = 4'(tok_row);
          state_next      = mfill_pkg::ST_DONE;
        end else begin
          cmd.tok_en = 1'b1;
          cnt_next   = cnt - DW'(1);
        end
      end
      mfill_pkg::ST_DONE: begin
        if (!rsp.valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = mfill_pkg::ST_IDLE;
        end
      end
      default: state_next = mfill_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.pos_col         <= 4'(cur_col);
      rsp.pos_row         <= 4'(cur_row);
      rsp.facing          <= heading;
      rsp.wall_ahead      <= cur_walls[heading];
      rsp.wall_left_side  <= cur_walls[mfill_pkg::left_of(heading)];
      rsp.wall_right_side <= cur_walls[mfill_pkg::right_of(heading)];
      rsp.wall_behind     <= cur_walls[mfill_pkg::back_of(heading)];
      rsp.next_col        <= plan_col;
      rsp.next_row        <= plan_row;
      rsp.next_valid      <= plan_valid;
      rsp.goal_distance   <= gd_out;
    end
  end

  for (genvar r = 0; r < GRID_SIDE; r++) begin : g_row
    for (genvar c = 0; c < GRID_SIDE; c++) begin : g_col
      localparam int IDX = r * GRID_SIDE + c;
      localparam logic [3:0] HAS = {c > 0, c < GRID_SIDE - 1, r < GRID_SIDE - 1, r > 0};
      localparam logic [3:0] RSTW = (c == 0 && r == GRID_SIDE - 1) ? 4'b1110 : 4'b0000;
      localparam int IN = (r > 0) ? IDX - GRID_SIDE : IDX;
      localparam int IS = (r < GRID_SIDE - 1) ? IDX + GRID_SIDE : IDX;
      localparam int IE = (c < GRID_SIDE - 1) ? IDX + 1 : IDX;
      localparam int IWT = (c > 0) ? IDX - 1 : IDX;

      logic [3:0][3:0]    n_walls;
      logic [3:0]         n_reached;
      logic [3:0][DW-1:0] n_dist;
      logic [3:0]         n_token;
      logic [3:0][3:0]    n_choice;

      assign n_walls   = {c_walls[IWT], c_walls[IE], c_walls[IS], c_walls[IN]};
      assign n_reached = {c_reached[IWT], c_reached[IE], c_reached[IS], c_reached[IN]};
      assign n_dist    = {c_dist[IWT], c_dist[IE], c_dist[IS], c_dist[IN]};
      assign n_token   = {c_token[IWT], c_token[IE], c_token[IS], c_token[IN]};
      assign n_choice  = {c_choice[IWT], c_choice[IE], c_choice[IS], c_choice[IN]};

      mfill_cell #(
        .COL       (c),
        .ROW       (r),
        .DW        (DW),
        .HAS_NBR   (HAS),
        .RST_WALLS (RSTW)
      ) u_cell (
        .clk         (clk),
        .rst         (rst),
        .cmd         (cmd),
        .wave        (wave),
        .nbr_walls   (n_walls),
        .nbr_reached (n_reached),
        .nbr_dist    (n_dist),
        .nbr_token   (n_token),
        .nbr_choice  (n_choice),
        .walls       (c_walls[IDX]),
        .reached     (c_reached[IDX]),
        .dist_val    (c_dist[IDX]),
        .token       (c_token[IDX]),
        .choice      (c_choice[IDX])
      );
    end
  end

endmodule
`default_nettype wire

@@ tb/mfill_checker.sv @@
`timescale 1ns / 1ps
module mfill_checker (
  input wire          clk,
  input wire          rst,
  mfill_req_if.sink   req,
  mfill_rsp_if.sink   rsp,
  mfill_cfg_if.sink   cfg,
  output int          fail_count,
  output int          pending_count
);

  localparam int SIDE = mfill_pkg::GRID_SIDE;
  localparam int CELLS = SIDE * SIDE;

  typedef struct packed {
    logic [3:0] pos_col;
    logic [3:0] pos_row;
    logic [1:0] facing;
    logic       wall_ahead;
    logic       wall_left_side;
    logic       wall_right_side;
    logic       wall_behind;
    logic [3:0] next_col;
    logic [3:0] next_row;
    logic       next_valid;
    logic [8:0] goal_distance;
  } status_t;

  logic [3:0] walls [CELLS];
  int         flood_dist [CELLS];
  int         bfs_queue [CELLS];
  int         robot_col, robot_row;
  logic [1:0] heading;
  int         step_col, step_row;
  logic       step_ok;
  int         lthr, rthr, gcol, grow;
  status_t    expected_status [$];

  function automatic logic [3:0] dir_mask(input logic [1:0] d);
    return 4'b0001 << d;
  endfunction

  function automatic int dcol(input logic [1:0] d);
    return (d == mfill_pkg::DIR_E) ? 1 : (d == mfill_pkg::DIR_W) ? -1 : 0;
  endfunction

  function automatic int drow(input logic [1:0] d);
    return (d == mfill_pkg::DIR_N) ? -1 : (d == mfill_pkg::DIR_S) ? 1 : 0;
  endfunction

  function automatic logic [1:0] turn_left(input logic [1:0] d);
    case (d)
      mfill_pkg::DIR_N: return mfill_pkg::DIR_W;
      mfill_pkg::DIR_S: return mfill_pkg::DIR_E;
      mfill_pkg::DIR_E: return mfill_pkg::DIR_N;
      default:          return mfill_pkg::DIR_S;
    endcase
  endfunction

  function automatic logic [1:0] turn_right(input logic [1:0] d);
    case (d)
      mfill_pkg::DIR_N: return mfill_pkg::DIR_E;
      mfill_pkg::DIR_S: return mfill_pkg::DIR_W;
      mfill_pkg::DIR_E: return mfill_pkg::DIR_S;
      default:          return mfill_pkg::DIR_N;
    endcase
  endfunction

  function automatic logic [1:0] opposite(input logic [1:0] d);
    case (d)
      mfill_pkg::DIR_N: return mfill_pkg::DIR_S;
      mfill_pkg::DIR_S: return mfill_pkg::DIR_N;
      mfill_pkg::DIR_E: return mfill_pkg::DIR_W;
      default:          return mfill_pkg::DIR_E;
    endcase
  endfunction

  function automatic logic [1:0] scan_dir(input int k);
    case (k)
      0:       return mfill_pkg::DIR_W;
      1:       return mfill_pkg::DIR_E;
      2:       return mfill_pkg::DIR_N;
      default: return mfill_pkg::DIR_S;
    endcase
  endfunction

  // Returns the neighbour index if the passage is open in both cells, else -1.
  function automatic int passage(input int c, input int r, input logic [1:0] d);
    int nc, nr;
    nc = c + dcol(d);
    nr = r + drow(d);
    if (nc < 0 || nc >= SIDE || nr < 0 || nr >= SIDE) return -1;
    if (walls[r*SIDE+c] & dir_mask(d)) return -1;
    if (walls[nr*SIDE+nc] & dir_mask(opposite(d))) return -1;
    return nr*SIDE + nc;
  endfunction

  task automatic plan_route();
    int head, tail, idx, nb, c, r, d;
    logic moved;
    logic [1:0] dir;
    for (int i = 0; i < CELLS; i++) flood_dist[i] = -1;
    idx = robot_row*SIDE + robot_col;
    flood_dist[idx] = 0;
    bfs_queue[0] = idx;
    head = 0;
    tail = 1;
    while (head < tail) begin
      idx = bfs_queue[head];
      head++;
      for (int k = 0; k < 4; k++) begin
        nb = passage(idx % SIDE, idx / SIDE, scan_dir(k));
        if (nb >= 0 && flood_dist[nb] == -1) begin
          flood_dist[nb] = flood_dist[idx] + 1;
          bfs_queue[tail] = nb;
          tail++;
        end
      end
    end
    step_ok = 1'b0;
    step_col = 0;
    step_row = 0;
    c = gcol;
    r = grow;
    d = flood_dist[r*SIDE+c];
    if (d < 1) return;
    while (d > 1) begin
      moved = 1'b0;
      for (int k = 0; k < 4 && !moved; k++) begin
        dir = scan_dir(k);
        nb = passage(c, r, dir);
        if (nb >= 0 && flood_dist[nb] == d - 1) begin
          c += dcol(dir);
          r += drow(dir);
          moved = 1'b1;
        end
      end
      if (!moved) return;
      d--;
    end
    step_col = c;
    step_row = r;
    step_ok = 1'b1;
  endtask

  task automatic apply_request(input logic [2:0] kind, input int lread, input int rread);
    int idx, nc, nr, gd;
    logic [3:0] w;
    status_t s;
    idx = robot_row*SIDE + robot_col;
    case (kind)
      mfill_pkg::REQ_FORWARD: begin
        nc = robot_col + dcol(heading);
        nr = robot_row + drow(heading);
        if (nc >= 0 && nc < SIDE && nr >= 0 && nr < SIDE) begin
          robot_col = nc;
          robot_row = nr;
        end
      end
      mfill_pkg::REQ_LEFT:  heading = turn_left(heading);
      mfill_pkg::REQ_RIGHT: heading = turn_right(heading);
      mfill_pkg::REQ_SENSE: begin
        if (lread > lthr - 25) walls[idx] |= dir_mask(turn_left(heading));
        if (rread > rthr - 25) walls[idx] |= dir_mask(turn_right(heading));
      end
      mfill_pkg::REQ_FRONT: walls[idx] |= dir_mask(heading);
      mfill_pkg::REQ_CLEAR: walls[idx] = 4'd0;
      mfill_pkg::REQ_PLAN:  plan_route();
      default: ;
    endcase
    w = walls[robot_row*SIDE + robot_col];
    gd = flood_dist[grow*SIDE + gcol];
    if (gd > 255) gd = 255;
    s.pos_col = robot_col[3:0];
    s.pos_row = robot_row[3:0];
    s.facing = heading;
    s.wall_ahead = |(w & dir_mask(heading));
    s.wall_left_side = |(w & dir_mask(turn_left(heading)));
    s.wall_right_side = |(w & dir_mask(turn_right(heading)));
    s.wall_behind = |(w & dir_mask(opposite(heading)));
    s.next_col = step_col[3:0];
    s.next_row = step_row[3:0];
    s.next_valid = step_ok;
    s.goal_distance = gd[8:0];
    expected_status = {expected_status, s};
  endtask

  task automatic compare_status(input status_t e);
    if (rsp.pos_col !== e.pos_col) begin
      $error("pos_col expected %0d actual %0d", e.pos_col, rsp.pos_col);
      fail_count++;
    end
    if (rsp.pos_row !== e.pos_row) begin
      $error("pos_row expected %0d actual %0d", e.pos_row, rsp.pos_row);
      fail_count++;
    end
    if (rsp.facing !== e.facing) begin
      $error("facing expected %0d actual %0d", e.facing, rsp.facing);
      fail_count++;
    end
    if (rsp.wall_ahead !== e.wall_ahead) begin
      $error("wall_ahead expected %0d actual %0d", e.wall_ahead, rsp.wall_ahead);
      fail_count++;
    end
    if (rsp.wall_left_side !== e.wall_left_side) begin
      $error("wall_left_side expected %0d actual %0d", e.wall_left_side, rsp.wall_left_side);
      fail_count++;
    end
    if (rsp.wall_right_side !== e.wall_right_side) begin
      $error("wall_right_side expected %0d actual %0d", e.wall_right_side,
             rsp.wall_right_side);
      fail_count++;
    end
    if (rsp.wall_behind !== e.wall_behind) begin
      $error("wall_behind expected %0d actual %0d", e.wall_behind, rsp.wall_behind);
      fail_count++;
    end
    if (rsp.next_col !== e.next_col) begin
      $error("next_col expected %0d actual %0d", e.next_col, rsp.next_col);
      fail_count++;
    end
    if (rsp.next_row !== e.next_row) begin
      $error("next_row expected %0d actual %0d", e.next_row, rsp.next_row);
      fail_count++;
    end
    if (rsp.next_valid !== e.next_valid) begin
      $error("next_valid expected %0d actual %0d", e.next_valid, rsp.next_valid);
      fail_count++;
    end
    if (rsp.goal_distance !== e.goal_distance) begin
      $error("goal_distance expected %0d actual %0d", $signed(e.goal_distance),
             rsp.goal_distance);
      fail_count++;
    end
  endtask

  assign pending_count = expected_status.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CELLS; i++) begin
        walls[i] = 4'd0;
        flood_dist[i] = -1;
      end
      robot_col = 0;
      robot_row = SIDE - 1;
      heading = mfill_pkg::DIR_S;
      walls[(SIDE-1)*SIDE] = dir_mask(mfill_pkg::DIR_S) | dir_mask(mfill_pkg::DIR_W) |
                             dir_mask(mfill_pkg::DIR_E);
      step_col = 0;
      step_row = 0;
      step_ok = 1'b0;
      lthr = 2048;
      rthr = 2048;
      gcol = 7;
      grow = 7;
      expected_status.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          mfill_pkg::CFG_LEFT_THR:  lthr = cfg.data;
          mfill_pkg::CFG_RIGHT_THR: rthr = cfg.data;
          mfill_pkg::CFG_GOAL_COL:  gcol = cfg.data[3:0];
          default:                  grow = cfg.data[3:0];
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_status.size() == 0) begin
          $error("result arrived with no request outstanding");
          fail_count++;
        end else begin
          compare_status(expected_status.pop_front());
        end
      end
      if (req.valid && req.ready)
        apply_request(req.req_type, req.left_reading, req.right_reading);
    end
  end
endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
module testbench;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count, pending_count;
  logic quiet_phase = 1'b0;
  logic hold_off = 1'b0;

  mfill_req_if req_ch();
  mfill_rsp_if rsp_ch();
  mfill_cfg_if cfg_ch();

  maze_mapper_flood_fill_unit uut (
    .clk(clk), .rst(rst), .req(req_ch.sink), .rsp(rsp_ch.source), .cfg(cfg_ch.sink)
  );

  mfill_checker checker_i (
    .clk(clk), .rst(rst), .req(req_ch.sink), .rsp(rsp_ch.sink), .cfg(cfg_ch.sink),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.req_type = mfill_pkg::REQ_STATUS;
    req_ch.left_reading = '0;
    req_ch.right_reading = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = mfill_pkg::CFG_LEFT_THR;
    cfg_ch.data = '0;
    rsp_ch.ready = 1'b0;
  end

  // Result side: random stalls, none in the quiet phase, a long hold-off on request.
  always @(posedge clk) begin
    if (rst || hold_off) rsp_ch.ready <= 1'b0;
    else if (quiet_phase) rsp_ch.ready <= 1'b1;
    else rsp_ch.ready <= ($urandom_range(99) >= 25);
  end

  // Valid stays up after an accepted item unless an idle cycle follows;
  // drain() and the idle loop take it down.
  task automatic send_request(input logic [2:0] kind, input logic [11:0] lr,
                              input logic [11:0] rr);
    cfg_ch.valid <= 1'b0;
    while (!quiet_phase && $urandom_range(99) < 25) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.left_reading <= lr;
    req_ch.right_reading <= rr;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [11:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // Mostly a wander through the maze with sensing and planning, some pure noise.
  task automatic random_requests(input int n);
    logic [2:0] kind;
    int roll;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < 30) kind = mfill_pkg::REQ_FORWARD;
      else if (roll < 45)
        kind = ($urandom_range(1) != 0) ? mfill_pkg::REQ_LEFT : mfill_pkg::REQ_RIGHT;
      else if (roll < 65) kind = mfill_pkg::REQ_SENSE;
      else if (roll < 75) kind = mfill_pkg::REQ_FRONT;
      else if (roll < 80) kind = mfill_pkg::REQ_CLEAR;
      else if (roll < 92) kind = mfill_pkg::REQ_PLAN;
      else kind = 3'($urandom_range(7));
      send_request(kind, 12'($urandom_range(4095)), 12'($urandom_range(4095)));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: edges, every request kind, reading extremes around the threshold.
    send_request(mfill_pkg::REQ_STATUS, 12'd0, 12'd0);
    send_request(mfill_pkg::REQ_PLAN, 12'd0, 12'd0);
    send_request(mfill_pkg::REQ_FORWARD, 12'd0, 12'd0);
    send_request(mfill_pkg::REQ_LEFT, 12'd0, 12'd0);
    send_request(mfill_pkg::REQ_SENSE, 12'd2023, 12'd2024);
    send_request(mfill_pkg::REQ_SENSE, 12'd4095, 12'd0);
    send_request(mfill_pkg::REQ_FORWARD, 12'd0, 12'd0);
    send_request(mfill_pkg::REQ_FRONT, 12'hfff, 12'hfff);
    send_request(mfill_pkg::REQ_CLEAR, 12'h555, 12'haaa);
    send_request(mfill_pkg::REQ_RIGHT, 12'haaa, 12'h555);
    send_request(mfill_pkg::REQ_RIGHT, 12'd0, 12'd0);
    send_request(mfill_pkg::REQ_FORWARD, 12'd0, 12'd0);
    send_request(mfill_pkg::REQ_PLAN, 12'd0, 12'd0);
    drain();

    // Low thresholds always mark; goal at the corner and equal to the robot's cell.
    write_register(mfill_pkg::CFG_LEFT_THR, 12'd0);
    write_register(mfill_pkg::CFG_RIGHT_THR, 12'd24);
    write_register(mfill_pkg::CFG_GOAL_COL, 12'd0);
    write_register(mfill_pkg::CFG_GOAL_ROW, 12'd15);
    send_request(mfill_pkg::REQ_SENSE, 12'd0, 12'd0);
    send_request(mfill_pkg::REQ_PLAN, 12'd0, 12'd0);
    drain();
    write_register(mfill_pkg::CFG_GOAL_COL, 12'd15);
    write_register(mfill_pkg::CFG_GOAL_ROW, 12'd0);
    send_request(mfill_pkg::REQ_PLAN, 12'd0, 12'd0);
    drain();

    write_register(mfill_pkg::CFG_LEFT_THR, 12'd4095);
    write_register(mfill_pkg::CFG_RIGHT_THR, 12'd4095);
    write_register(mfill_pkg::CFG_GOAL_COL, 12'd0);
    write_register(mfill_pkg::CFG_GOAL_ROW, 12'd0);
    send_request(mfill_pkg::REQ_SENSE, 12'd4070, 12'd4071);
    send_request(mfill_pkg::REQ_PLAN, 12'd0, 12'd0);
    drain();

    quiet_phase = 1'b1;
    random_requests(100);
    quiet_phase = 1'b0;
    random_requests(120);
    drain();

    write_register(mfill_pkg::CFG_LEFT_THR, 12'd2048);
    write_register(mfill_pkg::CFG_RIGHT_THR, 12'd1000);
    write_register(mfill_pkg::CFG_GOAL_COL, 12'd7);
    write_register(mfill_pkg::CFG_GOAL_ROW, 12'd8);
    // Receiver holds off while requests keep coming.
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      random_requests(20);
    join
    random_requests(150);
    drain();

    write_register(mfill_pkg::CFG_GOAL_COL, 12'($urandom_range(15)));
    write_register(mfill_pkg::CFG_GOAL_ROW, 12'($urandom_range(15)));
    write_register(mfill_pkg::CFG_LEFT_THR, 12'($urandom_range(4095)));
    random_requests(170);
    drain();

    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
